/* sv/sdfp_pkg.sv */
package sdfp_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIST_BITS  = 20;
	localparam int RAD_BITS   = 15;
	localparam int KIND_BITS  = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 3 * COORD_BITS;

	localparam int DIST_MAX = (1 << (DIST_BITS - 1)) - 1;
	localparam int DIST_MIN = -(1 << (DIST_BITS - 1));

	// square root: one result bit per stage plus a rounding stage
	localparam int SQ_IN_BITS   = 40;
	localparam int SQ_STEPS     = SQ_IN_BITS / 2;
	localparam int SQ_ROOT_BITS = SQ_STEPS + 1;
	localparam int SQRT_LAT     = SQ_STEPS + 1;

	// capsule projection divider: one quotient bit per stage
	localparam int DIV_N_BITS = 56;
	localparam int DIV_D_BITS = 37;
	localparam int DIV_Q_BITS = 18;
	localparam int DIV_LAT    = DIV_Q_BITS;

	// six front stages, divider, three stages, main root, two back stages
	localparam int PIPE_DEPTH = 6 + DIV_LAT + 3 + SQRT_LAT + 2;

	typedef enum logic [KIND_BITS-1:0] {
		SHAPE_SPHERE    = 3'd0,
		SHAPE_BOX       = 3'd1,
		SHAPE_ROUND_BOX = 3'd2,
		SHAPE_TORUS     = 3'd3,
		SHAPE_CYLINDER  = 3'd4,
		SHAPE_CAPSULE   = 3'd5
	} shape_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SHAPE_KIND   = 3'd0,
		CFG_POINT_A      = 3'd1,
		CFG_POINT_B      = 3'd2,
		CFG_RADIUS       = 3'd3,
		CFG_RADIUS_MINOR = 3'd4
	} cfg_reg_t;

endpackage

/* sv/sdfp_if.sv */
interface sdfp_query_if;
	import sdfp_pkg::*;
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface sdfp_result_if;
	import sdfp_pkg::*;
	logic valid;
	logic ready;
	logic signed [DIST_BITS-1:0] distance;
	logic degenerate_segment;
	modport source (output valid, distance, degenerate_segment, input ready);
	modport sink (input valid, distance, degenerate_segment, output ready);
endinterface

/* sv/sdf_primitive_evaluator.sv */
// Signed distance from a query point to one configured primitive.
//
// query  : one point per request (x, y, z, signed Q7.8).
// result : distance (signed Q11.8, saturated) and degenerate_segment, set
//          only for a capsule whose two endpoints coincide.
// cfg    : cfg_we / cfg_index / cfg_data write shape_kind, point_a, point_b,
//          radius and radius_minor. Write only while nothing is in flight.
//
// One request per cycle while the output is not stalled (see below).
// The depth comes from the capsule projection divider (18 stages, one
// quotient bit each) in series with the length square root (21 stages,
// one root bit each plus rounding); the torus ring root runs alongside
// the divider.
//
// The whole pipeline advances together. While a result waits at the
// output and result.ready is low, every stage holds and query.ready is
// low; nothing is dropped or duplicated.
//
// Reset clears all valid bits and loads the register defaults (sphere,
// radius 1.0, tube radius 0.25, both points at the origin).
module sdf_primitive_evaluator (
	input  logic clk,
	input  logic arst_n,
	sdfp_query_if.sink query,
	sdfp_result_if.source result,
	input  logic cfg_we,
	input  logic [sdfp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [sdfp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import sdfp_pkg::*;

	typedef struct packed {
		logic [2:0][COORD_BITS-1:0] p;
		logic [2:0][COORD_BITS:0]   pa;
		logic [2:0][COORD_BITS:0]   ba;
		logic [2:0][17:0]           qpos;
		logic [18:0]                mneg;
	} base_t;

	typedef struct packed {
		base_t      base;
		logic       den0;
		logic       nle;
		logic       nge;
		logic [2:0] neg;
	} cap_t;

	typedef struct packed {
		logic [18:0] mneg;
		logic        flag;
	} fin_t;

	// configuration
	logic [KIND_BITS-1:0]     shape_q;
	logic [CFG_DATA_BITS-1:0] pa_q;
	logic [CFG_DATA_BITS-1:0] pb_q;
	logic [RAD_BITS-1:0]      rad_q;
	logic [RAD_BITS-1:0]      radm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= SHAPE_SPHERE;
			pa_q    <= '0;
			pb_q    <= '0;
			rad_q   <= RAD_BITS'(256);
			radm_q  <= RAD_BITS'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHAPE_KIND:   shape_q <= cfg_data[KIND_BITS-1:0];
				CFG_POINT_A:      pa_q    <= cfg_data;
				CFG_POINT_B:      pb_q    <= cfg_data;
				CFG_RADIUS:       rad_q   <= cfg_data[RAD_BITS-1:0];
				CFG_RADIUS_MINOR: radm_q  <= cfg_data[RAD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	logic                en;
	logic [PIPE_DEPTH:1] vld_q;

	assign en          = !vld_q[PIPE_DEPTH] || result.ready;
	assign query.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-1:1], query.valid};
		end
	end

	// stage 1: offsets and box corner vectors
	logic signed [COORD_BITS-1:0] pin [3];
	logic signed [COORD_BITS-1:0] ca [3];
	logic signed [COORD_BITS-1:0] cb [3];
	logic signed [COORD_BITS:0]   off_c [3];
	logic signed [COORD_BITS:0]   dir_c [3];
	logic [COORD_BITS:0]          offm_c [3];
	logic [COORD_BITS-1:0]        pm_c [3];
	logic signed [18:0]           qbox_c [3];
	logic signed [18:0]           qrb_c [3];

	assign pin[0] = query.point_x;
	assign pin[1] = query.point_y;
	assign pin[2] = query.point_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ca[i]     = signed'(pa_q[COORD_BITS*i +: COORD_BITS]);
			cb[i]     = signed'(pb_q[COORD_BITS*i +: COORD_BITS]);
			off_c[i]  = (COORD_BITS+1)'(pin[i]) - (COORD_BITS+1)'(ca[i]);
			dir_c[i]  = (COORD_BITS+1)'(cb[i]) - (COORD_BITS+1)'(ca[i]);
			offm_c[i] = off_c[i][COORD_BITS] ? (COORD_BITS+1)'(-off_c[i]) : off_c[i];
			pm_c[i]   = pin[i][COORD_BITS-1] ? COORD_BITS'(-pin[i]) : pin[i];
			// doubled so the half size stays exact
			qbox_c[i] = signed'({1'b0, offm_c[i], 1'b0}) - 19'(cb[i]);
			qrb_c[i]  = signed'({2'b0, pm_c[i], 1'b0}) - 19'(cb[i])
				+ signed'({3'b0, rad_q, 1'b0});
		end
	end

	logic signed [COORD_BITS-1:0] p_s1 [3];
	logic signed [COORD_BITS:0]   pa_s1 [3];
	logic signed [COORD_BITS:0]   ba_s1 [3];
	logic signed [18:0]           qb_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i]  <= pin[i];
				pa_s1[i] <= off_c[i];
				ba_s1[i] <= dir_c[i];
				qb_s1[i] <= (shape_q == SHAPE_ROUND_BOX) ? qrb_c[i] : qbox_c[i];
			end
		end
	end

	// stage 2: products, box clamp and largest axis
	logic signed [18:0] mx_c;

	always_comb begin
		mx_c = qb_s1[0];
		if (qb_s1[1] > mx_c) mx_c = qb_s1[1];
		if (qb_s1[2] > mx_c) mx_c = qb_s1[2];
	end

	logic signed [33:0] pb_s2 [3];
	logic [33:0]        bb_s2 [3];
	logic signed [31:0] px2_s2;
	logic signed [31:0] py2_s2;
	base_t              base_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pb_s2[i]           <= pa_s1[i] * ba_s1[i];
				bb_s2[i]           <= ba_s1[i] * ba_s1[i];
				base_s2.p[i]       <= p_s1[i];
				base_s2.pa[i]      <= pa_s1[i];
				base_s2.ba[i]      <= ba_s1[i];
				base_s2.qpos[i]    <= qb_s1[i][18] ? 18'd0 : qb_s1[i][17:0];
			end
			px2_s2       <= p_s1[0] * p_s1[0];
			py2_s2       <= p_s1[1] * p_s1[1];
			base_s2.mneg <= mx_c[18] ? mx_c : '0;
		end
	end

	// stage 3: dot products, planar radius squared
	logic signed [35:0] num_s3;
	logic [35:0]        den_s3;
	logic [32:0]        rxy_s3;
	base_t              base_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3  <= 36'(pb_s2[0]) + 36'(pb_s2[1]) + 36'(pb_s2[2]);
			den_s3  <= 36'(bb_s2[0]) + 36'(bb_s2[1]) + 36'(bb_s2[2]);
			rxy_s3  <= 33'(px2_s2) + 33'(py2_s2);
			base_s3 <= base_s2;
		end
	end

	// torus ring distance root, lands next to the divider output
	logic [SQ_ROOT_BITS-1:0] root_t;

	sdfp_sqrt u_sqrt_ring (
		.clk      (clk),
		.en       (en),
		.radicand (SQ_IN_BITS'(rxy_s3)),
		.root     (root_t)
	);

	// stage 4: segment cases, split products of ba by the dot product
	logic               den0_s4;
	logic               nle_s4;
	logic               nge_s4;
	logic signed [35:0] lo_s4 [3];
	logic signed [35:0] hi_s4 [3];
	logic [35:0]        den_s4;
	base_t              base_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			den0_s4 <= den_s3 == '0;
			nle_s4  <= num_s3[35] || num_s3 == '0;
			nge_s4  <= signed'({num_s3[35], num_s3}) >= signed'({1'b0, den_s3});
			for (int i = 0; i < 3; i++) begin
				lo_s4[i] <= signed'(base_s3.ba[i]) * signed'({1'b0, num_s3[17:0]});
				hi_s4[i] <= signed'(base_s3.ba[i]) * signed'({1'b0, num_s3[35:18]});
			end
			den_s4  <= den_s3;
			base_s4 <= base_s3;
		end
	end

	// stage 5: dividend 2*ba*num + den
	logic signed [56:0] x_s5 [3];
	logic [DIV_D_BITS-1:0] dd_s5;
	logic               den0_s5;
	logic               nle_s5;
	logic               nge_s5;
	base_t              base_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				x_s5[i] <= (57'(hi_s4[i]) <<< 19) + (57'(lo_s4[i]) <<< 1)
					+ signed'(57'({1'b0, den_s4}));
			end
			dd_s5   <= {den_s4, 1'b0};
			den0_s5 <= den0_s4;
			nle_s5  <= nle_s4;
			nge_s5  <= nge_s4;
			base_s5 <= base_s4;
		end
	end

	// stage 6: fold a negative dividend so the floor comes from an unsigned divide
	logic [DIV_N_BITS-1:0] u_s6 [3];
	logic [DIV_D_BITS-1:0] dd_s6;
	cap_t                  cap_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cap_s6.neg[i] <= x_s5[i][56];
				u_s6[i] <= x_s5[i][56] ? DIV_N_BITS'(dd_s5) + ~x_s5[i][DIV_N_BITS-1:0]
					: x_s5[i][DIV_N_BITS-1:0];
			end
			dd_s6       <= dd_s5;
			cap_s6.den0 <= den0_s5;
			cap_s6.nle  <= nle_s5;
			cap_s6.nge  <= nge_s5;
			cap_s6.base <= base_s5;
		end
	end

	logic [DIV_Q_BITS-1:0] quo [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		sdfp_div u_div (
			.clk      (clk),
			.en       (en),
			.dividend (u_s6[i]),
			.divisor  (dd_s6),
			.quotient (quo[i])
		);
	end

	cap_t cap_d [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			cap_d[0] <= cap_s6;
			for (int k = 1; k < DIV_LAT; k++) begin
				cap_d[k] <= cap_d[k-1];
			end
		end
	end

	// stage 25: pick the vector whose length is measured
	cap_t               cap_c;
	logic signed [18:0] h_c [3];
	logic signed [19:0] capv_c [3];
	logic signed [21:0] t_c;
	logic signed [19:0] v_c [3];

	assign cap_c = cap_d[DIV_LAT-1];
	assign t_c   = signed'({1'b0, root_t}) - signed'({7'b0, rad_q});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			h_c[i] = signed'({1'b0, quo[i]});
			if (cap_c.neg[i]) h_c[i] = -h_c[i];
			if (cap_c.den0 || cap_c.nle) begin
				capv_c[i] = 20'(signed'(cap_c.base.pa[i]));
			end else if (cap_c.nge) begin
				capv_c[i] = 20'(signed'(cap_c.base.pa[i])) - 20'(signed'(cap_c.base.ba[i]));
			end else begin
				capv_c[i] = 20'(signed'(cap_c.base.pa[i])) - 20'(h_c[i]);
			end
		end
		unique case (shape_q)
			SHAPE_BOX, SHAPE_ROUND_BOX: begin
				for (int i = 0; i < 3; i++) v_c[i] = signed'({2'b0, cap_c.base.qpos[i]});
			end
			SHAPE_TORUS: begin
				v_c[0] = 20'(t_c);
				v_c[1] = 20'(signed'(cap_c.base.p[2]));
				v_c[2] = '0;
			end
			SHAPE_CYLINDER: begin
				v_c[0] = 20'(signed'(cap_c.base.p[0]));
				v_c[1] = 20'(signed'(cap_c.base.p[1]));
				v_c[2] = '0;
			end
			SHAPE_CAPSULE: begin
				for (int i = 0; i < 3; i++) v_c[i] = capv_c[i];
			end
			default: begin
				for (int i = 0; i < 3; i++) v_c[i] = 20'(signed'(cap_c.base.pa[i]));
			end
		endcase
	end

	logic signed [19:0] v_s25 [3];
	fin_t               fin_s25;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) v_s25[i] <= v_c[i];
			fin_s25.mneg <= cap_c.base.mneg;
			fin_s25.flag <= (shape_q == SHAPE_CAPSULE) && cap_c.den0;
		end
	end

	// stages 26 and 27: sum of squares
	logic [SQ_IN_BITS-1:0] sq_s26 [3];
	fin_t                  fin_s26;
	logic [SQ_IN_BITS-1:0] rad_s27;
	fin_t                  fin_s27;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s26[i] <= v_s25[i] * v_s25[i];
			fin_s26 <= fin_s25;
			rad_s27 <= sq_s26[0] + sq_s26[1] + sq_s26[2];
			fin_s27 <= fin_s26;
		end
	end

	logic [SQ_ROOT_BITS-1:0] root_m;

	sdfp_sqrt u_sqrt_len (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s27),
		.root     (root_m)
	);

	fin_t fin_d [SQRT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			fin_d[0] <= fin_s27;
			for (int k = 1; k < SQRT_LAT; k++) begin
				fin_d[k] <= fin_d[k-1];
			end
		end
	end

	// stage 49: shape offset, halve the doubled box result rounding up
	fin_t               fin_c;
	logic signed [22:0] rt_c;
	logic signed [22:0] mn_c;
	logic signed [22:0] sum_c;
	logic signed [22:0] d_c;

	assign fin_c = fin_d[SQRT_LAT-1];
	assign rt_c  = signed'({2'b0, root_m});
	assign mn_c  = 23'(signed'(fin_c.mneg));

	always_comb begin
		sum_c = '0;
		unique case (shape_q)
			SHAPE_BOX: begin
				sum_c = rt_c + mn_c + 23'sd1;
				d_c   = sum_c >>> 1;
			end
			SHAPE_ROUND_BOX: begin
				sum_c = rt_c + mn_c - signed'({7'b0, rad_q, 1'b0}) + 23'sd1;
				d_c   = sum_c >>> 1;
			end
			SHAPE_TORUS: d_c = rt_c - signed'({8'b0, radm_q});
			default:     d_c = rt_c - signed'({8'b0, rad_q});
		endcase
	end

	logic signed [22:0] d_s49;
	logic               flag_s49;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s49    <= d_c;
			flag_s49 <= fin_c.flag;
		end
	end

	// stage 50: saturate into the output register
	logic signed [DIST_BITS-1:0] dist_s50;
	logic                        flag_s50;

	always_ff @(posedge clk) begin
		if (en) begin
			if (d_s49 > 23'(DIST_MAX)) begin
				dist_s50 <= DIST_BITS'(DIST_MAX);
			end else if (d_s49 < 23'(DIST_MIN)) begin
				dist_s50 <= DIST_BITS'(DIST_MIN);
			end else begin
				dist_s50 <= d_s49[DIST_BITS-1:0];
			end
			flag_s50 <= flag_s49;
		end
	end

	assign result.valid              = vld_q[PIPE_DEPTH];
	assign result.distance           = dist_s50;
	assign result.degenerate_segment = flag_s50;

endmodule

/* sv/sdfp_sqrt.sv */
module sdfp_sqrt (
	input  logic clk,
	input  logic en,
	input  logic [sdfp_pkg::SQ_IN_BITS-1:0] radicand,
	output logic [sdfp_pkg::SQ_ROOT_BITS-1:0] root
);
	import sdfp_pkg::*;

	logic [SQ_IN_BITS-1:0] rem_s [SQ_STEPS];
	logic [SQ_IN_BITS-1:0] acc_s [SQ_STEPS];
	logic [SQ_ROOT_BITS-1:0] root_q;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_IN_BITS-1:0] BIT = SQ_IN_BITS'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQ_IN_BITS-1:0] rem_in;
		logic [SQ_IN_BITS-1:0] acc_in;
		logic [SQ_IN_BITS-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = radicand;
			assign acc_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		assign trial = acc_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					acc_s[k] <= (acc_in >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_in;
					acc_s[k] <= acc_in >> 1;
				end
			end
		end
	end

	// round to nearest: bump when the remainder exceeds the floor root
	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= SQ_ROOT_BITS'(acc_s[SQ_STEPS-1])
				+ SQ_ROOT_BITS'(rem_s[SQ_STEPS-1] > acc_s[SQ_STEPS-1]);
		end
	end

	assign root = root_q;

endmodule

/* sv/sdfp_div.sv */
module sdfp_div (
	input  logic clk,
	input  logic en,
	input  logic [sdfp_pkg::DIV_N_BITS-1:0] dividend,
	input  logic [sdfp_pkg::DIV_D_BITS-1:0] divisor,
	output logic [sdfp_pkg::DIV_Q_BITS-1:0] quotient
);
	import sdfp_pkg::*;

	logic [DIV_N_BITS-1:0] rem_s [DIV_Q_BITS-1];
	logic [DIV_D_BITS-1:0] dvs_s [DIV_Q_BITS-1];
	logic [DIV_Q_BITS-1:0] quo_s [DIV_Q_BITS];

	for (genvar k = 0; k < DIV_Q_BITS; k++) begin : g_step
		localparam int SH = DIV_Q_BITS - 1 - k;
		logic [DIV_N_BITS-1:0] rem_in;
		logic [DIV_N_BITS-1:0] sub;
		logic [DIV_D_BITS-1:0] dvs_in;
		logic [DIV_Q_BITS-1:0] quo_in;
		logic take;

		if (k == 0) begin : g_first
			assign rem_in = dividend;
			assign dvs_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign sub  = DIV_N_BITS'(dvs_in) << SH;
		assign take = rem_in >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_in[DIV_Q_BITS-2:0], take};
			end
		end

		if (k < DIV_Q_BITS - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? rem_in - sub : rem_in;
					dvs_s[k] <= dvs_in;
				end
			end
		end
	end

	assign quotient = quo_s[DIV_Q_BITS-1];

endmodule

/* bench/tb_sdf_primitive_evaluator.sv */
module tb_sdf_primitive_evaluator;
	timeunit 1ns;
	timeprecision 1ps;
	import sdfp_pkg::*;

	localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;
	localparam int IDLE_PCT = 13;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic signed [DIST_BITS-1:0] dist_val;
		logic flag;
	} dist_rec_t;

	typedef struct {
		logic [KIND_BITS-1:0] kind;
		logic [CFG_DATA_BITS-1:0] a;
		logic [CFG_DATA_BITS-1:0] b;
		logic [RAD_BITS-1:0] r;
		logic [RAD_BITS-1:0] rm;
	} shape_cfg_t;

	typedef struct {
		shape_cfg_t cfg;
		logic signed [COORD_BITS-1:0] x, y, z;
		logic known;
		dist_rec_t want;
	} query_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	sdfp_query_if query ();
	sdfp_result_if result ();

	sdf_primitive_evaluator dut (
		.clk(clk),
		.arst_n(arst_n),
		.query(query.sink),
		.result(result.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	shape_cfg_t shape_now;
	dist_rec_t pending_dist[$];
	query_row_t directed_rows[$];
	int errors = 0;
	logic no_idle = 1'b0;
	int quiet_cycles = 0;

	task automatic report(input string what);
		$display("ERROR %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic longint unsigned round_root(input longint unsigned n);
		longint unsigned r, bt;
		r = 0;
		bt = 64'h4000_0000_0000_0000;
		while (bt > n)
			bt >>= 2;
		while (bt != 0) begin
			if (n >= r + bt) begin
				n -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		if (n > r)
			r++;
		return r;
	endfunction

	function automatic longint norm3(input longint x, input longint y, input longint z);
		return longint'(round_root(longint'(x * x + y * y + z * z)));
	endfunction

	function automatic longint floor_div(input longint n, input longint d);
		if (n >= 0)
			return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint pos(input longint v);
		return v > 0 ? v : 0;
	endfunction

	function automatic longint box_core(input longint qx, input longint qy, input longint qz);
		longint m;
		m = qx;
		if (qy > m) m = qy;
		if (qz > m) m = qz;
		return norm3(pos(qx), pos(qy), pos(qz)) + (m < 0 ? m : 0);
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pack3(input int x, input int y, input int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic dist_rec_t predict_distance(input shape_cfg_t c,
			input logic signed [COORD_BITS-1:0] px, py, pz);
		longint p[3], a[3], b[3], q[3], pa[3], ba[3];
		longint d, t, num, den, r, rm;
		dist_rec_t res;
		p[0] = px; p[1] = py; p[2] = pz;
		r = c.r;
		rm = c.rm;
		num = 0;
		den = 0;
		res.flag = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a[i] = longint'($signed(c.a[16*i +: 16]));
			b[i] = longint'($signed(c.b[16*i +: 16]));
		end
		case (c.kind)
			SHAPE_BOX: begin
				for (int i = 0; i < 3; i++)
					q[i] = 2 * mag(p[i] - a[i]) - b[i];
				d = floor_div(box_core(q[0], q[1], q[2]) + 1, 2);
			end
			SHAPE_ROUND_BOX: begin
				for (int i = 0; i < 3; i++)
					q[i] = 2 * mag(p[i]) - b[i] + 2 * r;
				d = floor_div(box_core(q[0], q[1], q[2]) - 2 * r + 1, 2);
			end
			SHAPE_TORUS: begin
				t = norm3(p[0], p[1], 0) - r;
				d = norm3(t, p[2], 0) - rm;
			end
			SHAPE_CYLINDER: d = norm3(p[0], p[1], 0) - r;
			SHAPE_CAPSULE: begin
				for (int i = 0; i < 3; i++) begin
					pa[i] = p[i] - a[i];
					ba[i] = b[i] - a[i];
					num += pa[i] * ba[i];
					den += ba[i] * ba[i];
				end
				for (int i = 0; i < 3; i++) begin
					if (den == 0 || num <= 0)
						q[i] = pa[i];
					else if (num >= den)
						q[i] = pa[i] - ba[i];
					else
						q[i] = pa[i] - floor_div(2 * ba[i] * num + den, 2 * den);
				end
				res.flag = (den == 0);
				d = norm3(q[0], q[1], q[2]) - r;
			end
			default: d = norm3(p[0] - a[0], p[1] - a[1], p[2] - a[2]) - r;
		endcase
		if (d > DIST_MAX) d = DIST_MAX;
		if (d < DIST_MIN) d = DIST_MIN;
		res.dist_val = DIST_BITS'(d);
		return res;
	endfunction

	// valid is left high after an accept; the next call or settle decides it
	task automatic send_point(input logic signed [COORD_BITS-1:0] x, y, z,
			input logic known, input dist_rec_t want);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			query.valid <= 1'b0;
			@(posedge clk);
		end
		query.valid <= 1'b1;
		query.point_x <= x;
		query.point_y <= y;
		query.point_z <= z;
		do @(posedge clk); while (!query.ready);
		pending_dist = {pending_dist, (known ? want : predict_distance(shape_now, x, y, z))};
	endtask

	task automatic settle(input int extra);
		query.valid <= 1'b0;
		while (pending_dist.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// write only the registers that change; the pipe is drained before the first write
	task automatic apply_shape(input shape_cfg_t c);
		logic [CFG_DATA_BITS-1:0] vals[5];
		logic [CFG_DATA_BITS-1:0] olds[5];
		logic wrote;
		wrote = 1'b0;
		vals = '{48'(c.kind), c.a, c.b, 48'(c.r), 48'(c.rm)};
		olds = '{48'(shape_now.kind), shape_now.a, shape_now.b, 48'(shape_now.r),
			48'(shape_now.rm)};
		for (int k = 0; k < 5; k++) begin
			if (vals[k] != olds[k]) begin
				if (!wrote)
					settle(PIPE_DEPTH + 4);
				wrote = 1'b1;
				cfg_we <= 1'b1;
				cfg_index <= CFG_IDX_BITS'(k);
				cfg_data <= vals[k];
				@(posedge clk);
			end
		end
		cfg_we <= 1'b0;
		shape_now = c;
	endtask

	task automatic add_row(input shape_cfg_t c, input int x, y, z,
			input logic known, input int dist_in, input logic flag);
		query_row_t row;
		row.cfg = c;
		row.x = 16'(x);
		row.y = 16'(y);
		row.z = 16'(z);
		row.known = known;
		row.want.dist_val = DIST_BITS'(dist_in);
		row.want.flag = flag;
		directed_rows = {directed_rows, row};
	endtask

	function automatic shape_cfg_t mk(input logic [KIND_BITS-1:0] kind,
			input logic [CFG_DATA_BITS-1:0] a, b, input int r, rm);
		shape_cfg_t c;
		c.kind = kind;
		c.a = a;
		c.b = b;
		c.r = RAD_BITS'(r);
		c.rm = RAD_BITS'(rm);
		return c;
	endfunction

	function automatic shape_cfg_t random_shape();
		shape_cfg_t c;
		c.kind = KIND_BITS'($urandom_range(7));
		c.a = ($urandom_range(1)) ? {16'($urandom), 16'($urandom), 16'($urandom)}
			: pack3($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
				$urandom_range(4000) - 2000);
		c.b = ($urandom_range(1)) ? {16'($urandom), 16'($urandom), 16'($urandom)}
			: pack3($urandom_range(3000), $urandom_range(3000), $urandom_range(3000));
		if (c.kind == SHAPE_CAPSULE && $urandom_range(3) == 0)
			c.b = c.a;
		case ($urandom_range(3))
			0: c.r = '0;
			1: c.r = '1;
			default: c.r = RAD_BITS'($urandom_range(2000));
		endcase
		c.rm = ($urandom_range(3) == 0) ? RAD_BITS'($urandom) : RAD_BITS'($urandom_range(600));
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (pending_dist.size() == 0) begin
					report($sformatf("unexpected result distance %0d", result.distance));
				end else begin
					dist_rec_t w;
					w = pending_dist.pop_front();
					if (result.distance !== w.dist_val)
						report($sformatf("distance %0d, want %0d", result.distance,
							w.dist_val));
					if (result.degenerate_segment !== w.flag)
						report($sformatf("degenerate_segment %b, want %b",
							result.degenerate_segment, w.flag));
				end
			end
			result.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((query.valid && query.ready) || (result.valid && result.ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		shape_cfg_t c;
		shape_cfg_t base;
		int n;
		int hold_at;
		logic signed [COORD_BITS-1:0] x, y, z;
		query.valid = 1'b0;
		query.point_x = '0;
		query.point_y = '0;
		query.point_z = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		shape_now = mk(SHAPE_SPHERE, '0, '0, 256, 64);
		base = shape_now;

		// reset defaults: unit sphere at the origin
		add_row(base, 0, 0, 0, 1, -256, 0);
		add_row(base, 256, 0, 0, 1, 0, 0);
		add_row(mk(SHAPE_SPHERE, '0, '0, 0, 64), -32768, -32768, -32768, 0, 0, 0);
		add_row(mk(SHAPE_SPHERE, pack3(32767, 32767, 32767), '0, 0, 64),
			-32768, -32768, -32768, 0, 0, 0);
		add_row(mk(SHAPE_SPHERE, pack3(-32768, 5, 7), '0, 32767, 64), -32768, 5, 7,
			1, -32767, 0);
		// box uses the absolute offset from its centre
		add_row(mk(SHAPE_BOX, '0, pack3(512, 512, 512), 0, 0), 0, 0, 0, 1, -256, 0);
		add_row(mk(SHAPE_BOX, '0, pack3(512, 512, 512), 0, 0), -1024, 0, 0, 1, 768, 0);
		add_row(mk(SHAPE_BOX, pack3(300, -200, 100), pack3(-32768, 32767, 1), 0, 0),
			32767, -32768, 3, 0, 0, 0);
		add_row(mk(SHAPE_ROUND_BOX, pack3(999, 999, 999), pack3(800, 600, 400), 100, 0),
			-700, 300, 250, 0, 0, 0);
		add_row(mk(SHAPE_ROUND_BOX, '0, pack3(800, 600, 400), 32767, 0), 1, 2, 3, 0, 0, 0);
		add_row(mk(SHAPE_TORUS, '0, '0, 256, 64), 0, 0, 0, 1, 192, 0);
		add_row(mk(SHAPE_TORUS, '0, '0, 256, 32767), 256, 0, 32767, 0, 0, 0);
		add_row(mk(SHAPE_CYLINDER, pack3(500, 500, 500), '0, 256, 64), 0, 0, 1000,
			1, -256, 0);
		add_row(mk(SHAPE_CYLINDER, '0, '0, 0, 64), -32768, 32767, 0, 0, 0, 0);
		// coincident capsule endpoints fall back to a sphere and raise the flag
		add_row(mk(SHAPE_CAPSULE, pack3(100, 200, 300), pack3(100, 200, 300), 256, 64),
			100, 200, 300, 1, -256, 1);
		add_row(mk(SHAPE_CAPSULE, '0, pack3(1024, 0, 0), 256, 64), 512, 256, 0, 0, 0, 0);
		add_row(mk(SHAPE_CAPSULE, '0, pack3(1024, 0, 0), 256, 64), -300, 40, 9, 0, 0, 0);
		add_row(mk(SHAPE_CAPSULE, '0, pack3(1024, 0, 0), 256, 64), 5000, 40, 9, 0, 0, 0);
		add_row(mk(SHAPE_CAPSULE, pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
			0, 64), 333, -77, 12345, 0, 0, 0);
		add_row(mk(KIND_SPARE_LO, pack3(10, 20, 30), '0, 256, 64), 10, 20, 30, 0, 0, 0);
		add_row(mk(KIND_SPARE_HI, pack3(10, 20, 30), '0, 256, 64), -9, 8, 7, 0, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			apply_shape(directed_rows[i].cfg);
			send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
				directed_rows[i].known, directed_rows[i].want);
		end

		for (int ph = 0; ph < 12; ph++) begin
			c = random_shape();
			apply_shape(c);
			no_idle = (ph == 4);
			n = 80;
			hold_at = $urandom_range(n - 1);
			for (int k = 0; k < n; k++) begin
				if (k == hold_at)
					settle(0);
				if ($urandom_range(1)) begin
					x = 16'($urandom);
					y = 16'($urandom);
					z = 16'($urandom);
				end else begin
					// stay near the surface where the shape logic matters
					x = 16'($signed(c.a[15:0]) + $signed(16'($urandom_range(2048))) - 1024);
					y = 16'($signed(c.a[31:16]) + $signed(16'($urandom_range(2048))) - 1024);
					z = 16'($signed(c.a[47:32]) + $signed(16'($urandom_range(2048))) - 1024);
				end
				send_point(x, y, z, 1'b0, '0);
			end
			settle(0);
			no_idle = 1'b0;
		end

		settle(PIPE_DEPTH + 10);
		if (errors == 0 && pending_dist.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* sdf_primitive_evaluator.f */
sv/sdfp_pkg.sv
sv/sdfp_if.sv
sv/sdfp_sqrt.sv
sv/sdfp_div.sv
sv/sdf_primitive_evaluator.sv
bench/tb_sdf_primitive_evaluator.sv
